>>> rtl/qbel_pkg.sv
// Shared types, codes and the quadrature step table of the button event latch.
`default_nettype none

package qbel_pkg;

  // Number of active-low buttons and their bit positions in the button word.
  localparam int unsigned NumButtons = 7;
  localparam int unsigned BtnLeft    = 0;
  localparam int unsigned BtnRight   = 1;
  localparam int unsigned BtnDown    = 2;
  localparam int unsigned BtnUp      = 3;
  localparam int unsigned BtnAck     = 4;
  localparam int unsigned BtnLaunch  = 5;
  localparam int unsigned BtnStart   = 6;

  // Widths of the stream beats.
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 8;

  typedef enum logic [3:0] {
    KIND_LEFT   = 4'd0,
    KIND_RIGHT  = 4'd1,
    KIND_DOWN   = 4'd2,
    KIND_UP     = 4'd3,
    KIND_ACK    = 4'd4,
    KIND_CW     = 4'd5,
    KIND_CCW    = 4'd6,
    KIND_LAUNCH = 4'd7,
    KIND_START  = 4'd8
  } kind_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_e;

  typedef struct packed {
    logic [1:0]            phases;
    logic [NumButtons-1:0] buttons;
    logic                  handled;
  } sample_t;

  typedef struct packed {
    logic [1:0]            last_phases;
    logic                  cw_flag;
    logic                  ccw_flag;
    logic [NumButtons-1:0] last_buttons;
    logic                  pending;
    kind_e                 held_kind;
  } state_t;

  typedef struct packed {
    logic  action_pending;
    kind_e action_kind;
    logic  new_action;
  } result_t;

  // Gray-code step from the previous phase pair to the current one.
  function automatic dir_e quad_step(input logic [1:0] prev, input logic [1:0] cur);
    dir_e d;
    d = DIR_NONE;
    case (cur)
      2'b00: d = (prev == 2'b01) ? DIR_CW : ((prev == 2'b10) ? DIR_CCW : DIR_NONE);
      2'b01: d = (prev == 2'b11) ? DIR_CW : ((prev == 2'b00) ? DIR_CCW : DIR_NONE);
      2'b10: d = (prev == 2'b00) ? DIR_CW : ((prev == 2'b11) ? DIR_CCW : DIR_NONE);
      2'b11: d = (prev == 2'b10) ? DIR_CW : ((prev == 2'b01) ? DIR_CCW : DIR_NONE);
      default: d = DIR_NONE;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

>>> rtl/qbel_step.sv
// Combinational update of the encoder flags and the priority event latch for one tick.
`default_nettype none

module qbel_step (
  input  qbel_pkg::state_t  state_i,
  input  qbel_pkg::sample_t sample_i,
  output qbel_pkg::state_t  state_o,
  output qbel_pkg::result_t result_o
);
  import qbel_pkg::*;

  logic                  pend;
  dir_e                  dir;
  logic                  cw;
  logic                  ccw;
  logic [NumButtons-1:0] fell;
  logic                  fresh;
  kind_e                 kind;

  always_comb begin
    pend = state_i.pending & ~sample_i.handled;
    dir  = quad_step(state_i.last_phases, sample_i.phases);
    cw   = state_i.cw_flag  | (dir == DIR_CW);
    ccw  = state_i.ccw_flag | (dir == DIR_CCW);
    fell = state_i.last_buttons & ~sample_i.buttons;

    fresh = 1'b0;
    kind  = state_i.held_kind;
    if (!pend) begin
      fresh = 1'b1;
      if (fell[BtnLeft]) begin
        kind = KIND_LEFT;
      end else if (fell[BtnRight]) begin
        kind = KIND_RIGHT;
      end else if (fell[BtnDown]) begin
        kind = KIND_DOWN;
      end else if (fell[BtnUp]) begin
        kind = KIND_UP;
      end else if (fell[BtnAck]) begin
        kind = KIND_ACK;
      end else if (cw) begin
        kind = KIND_CW;
        cw   = 1'b0;
      end else if (ccw) begin
        kind = KIND_CCW;
        ccw  = 1'b0;
      end else if (fell[BtnLaunch]) begin
        kind = KIND_LAUNCH;
      end else if (fell[BtnStart]) begin
        kind = KIND_START;
      end else begin
        fresh = 1'b0;
      end
    end

    state_o.last_phases  = sample_i.phases;
    state_o.cw_flag      = cw;
    state_o.ccw_flag     = ccw;
    state_o.last_buttons = sample_i.buttons;
    state_o.pending      = pend | fresh;
    state_o.held_kind    = kind;

    result_o.action_pending = pend | fresh;
    result_o.action_kind    = (pend | fresh) ? kind : KIND_LEFT;
    result_o.new_action     = fresh;
  end

endmodule

`default_nettype wire

>>> rtl/quadrature_button_event_latch.sv
// Top level of the quadrature encoder and button event latch.
//
// Usage: each input beat on the s_axis channel is one sample tick of the
// encoder phases, the seven active-low buttons and the consumer's handled
// flag. For every input beat exactly one output beat appears on m_axis,
// carrying the pending flag, the held action kind and whether an action
// was latched in that tick. Beats leave in the order they entered.
//
// An input beat passes through the sample register, then through the step
// logic into the result register. Throughput is one beat per cycle while
// the receiver does not stall; the limit is the single state register that
// the step logic reads and writes every tick.
//
// Reset clears both pipeline valid bits, the phase history, the rotation
// flags and the pending action, and sets the button history to released.
// When the receiver stalls, the result register holds its beat; the sample
// register then fills and s_axis_tready drops until the result is taken.
// The state advances only when a sample moves into the result register.
`default_nettype none

module quadrature_button_event_latch (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // From bit 0: phase_a, phase_b, nav_left, nav_right, nav_down, nav_up,
  // ack_button, launch_button, start, handled, then zero fill.
  input  logic [qbel_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // From bit 0: action_pending, action_kind[3:0], new_action, then zero fill.
  output logic [qbel_pkg::OutDataW-1:0]  m_axis_tdata
);
  import qbel_pkg::*;

  // Sample register.
  logic    in_valid_q;
  sample_t in_data_q;
  sample_t in_data_d;

  // Result register.
  logic    out_valid_q;
  result_t out_data_q;

  // Architectural state of the latch.
  state_t  state_q;
  state_t  state_d;
  result_t result;

  logic    advance;
  logic    in_take;

  // A sample moves on when the result register is empty or being emptied.
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;
  assign in_take       = s_axis_tvalid & s_axis_tready;

  // The phase pair puts phase A in the upper bit.
  always_comb begin
    in_data_d.phases  = {s_axis_tdata[0], s_axis_tdata[1]};
    in_data_d.buttons = s_axis_tdata[8:2];
    in_data_d.handled = s_axis_tdata[9];
  end

  qbel_step u_step (
    .state_i  (state_q),
    .sample_i (in_data_q),
    .state_o  (state_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (~out_valid_q | m_axis_tready) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.last_phases  <= 2'b00;
      state_q.cw_flag      <= 1'b0;
      state_q.ccw_flag     <= 1'b0;
      state_q.last_buttons <= '1;
      state_q.pending      <= 1'b0;
      state_q.held_kind    <= KIND_LEFT;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_data_q.new_action, out_data_q.action_kind,
                          out_data_q.action_pending};

endmodule

`default_nettype wire

>>> rtl/qbel_checker.sv
// Port-level checks of the button event latch and their binding to the top level.
`default_nettype none

module qbel_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);
  import qbel_pkg::*;

  // A freshly latched action is always reported as pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[5]) |-> m_axis_tdata[0])
    else $error("new action without pending flag");

  // With nothing pending the kind field reads as zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[4:1] == 4'd0))
    else $error("kind not zero while idle");

  // A stalled output beat holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output beat changed");

  // The input is only held off while the output is stalled.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
    else $error("input stalled while output is free");

  // Once reset has been seen at an edge, no output beat is offered next.
  assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

endmodule

bind quadrature_button_event_latch qbel_checker u_qbel_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
